FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker of this project, bb3_checker.
// They expect aclk and aresetn in the scope where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define BB3_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge out of reset.
`define BB3_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/bb3_pkg.sv
// Shared types and constants of the 3x3 box blur block.
// No dependencies; bb3_res_fifo, box_blur_3x3 and bb3_checker import it.
`default_nettype none

package bb3_pkg;

    localparam int ROW_BITS       = 10;
    localparam int COL_BITS       = 10;
    localparam int PIX_OUT_BITS   = 16;
    localparam int S_TDATA_BITS   = 16;
    localparam int M_TDATA_BITS   = 40;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 11;
    localparam int MAX_ROWS       = 1024;

    // One input pixel causes at most this many results.
    localparam int RUN_MAX        = 3;

    // Result queue geometry.
    localparam int RES_DEPTH      = 16;
    localparam int RES_PTR_BITS   = 4;
    localparam int RES_CNT_BITS   = 5;

    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;

    typedef struct packed {
        logic [ROW_BITS-1:0]     row;
        logic [COL_BITS-1:0]     col;
        logic [PIX_OUT_BITS-1:0] pixel;
        logic                    run_last;
        logic                    frame_done;
    } result_t;

    // Results of one input pixel, all written into the queue in the same cycle.
    typedef struct packed {
        logic [1:0]                count;
        result_t [RUN_MAX-1:0]     item;
    } push_t;

endpackage

`default_nettype wire

FILE: rtl/core/bb3_line_buf.sv
// Line buffer memory of the box blur: one entry per column holds the two
// previous rows of that column. Registered read. Uses no package items.
`default_nettype none

module bb3_line_buf #(
    parameter int DEPTH     = 1024,
    parameter int DATA_BITS = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [DATA_BITS-1:0]     rd_data,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [DATA_BITS-1:0]     wr_data
);

    logic [DATA_BITS-1:0] mem [DEPTH];

    // A read and a write to the same address in the same cycle return the old data.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/bb3_res_fifo.sv
// Result queue of the box blur: takes up to three results per cycle and
// hands out one per cycle while pop is high. Depends on bb3_pkg.
`default_nettype none

module bb3_res_fifo (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire bb3_pkg::push_t                  push,
    input  wire logic                            pop,
    output bb3_pkg::result_t                     head,
    output logic [bb3_pkg::RES_CNT_BITS-1:0]     count
);

    import bb3_pkg::*;

    result_t                  mem [RES_DEPTH];
    logic [RES_PTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [RES_PTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [RES_CNT_BITS-1:0]  count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + RES_PTR_BITS'(push.count);
        rd_ptr_next = rd_ptr_reg + RES_PTR_BITS'(pop);
        count_next  = count_reg + RES_CNT_BITS'(push.count) - RES_CNT_BITS'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < RUN_MAX; k++) begin
            if (2'(k) < push.count) begin
                mem[wr_ptr_reg + RES_PTR_BITS'(k)] <= push.item[k];
            end
        end
    end

    assign head  = mem[rd_ptr_reg];
    assign count = count_reg;

endmodule

`default_nettype wire

FILE: rtl/core/box_blur_3x3.sv
// 3x3 box blur over a raster-order grayscale pixel stream.
//
// Pixels enter on the s_ channel, one per request, row after row. Each
// result on the m_ channel carries its own row and column: an interior pixel
// becomes the truncated mean of its 3x3 neighborhood, border pixels pass
// through. One input pixel causes zero to three results; the last of them
// has m_tlast set, and m_tuser marks every result caused by the final pixel
// of a frame. Frame size is written on the cfg_ channel (index 0 width,
// index 1 height); the user must do so only while the block is idle; the
// block does not enforce this. Width and height writes restart the frame.
//
// A pixel can be accepted every cycle while s_tready is high; the sustained
// rate is one result per cycle, set by the single output port, so rows that
// give two or three results per pixel slow the input to match. A 16-entry
// result queue sits between the pipeline and the output, so a stalled
// receiver only stops the input once the queue runs short of room for the
// pixels in flight. Reset (aresetn low, synchronous) empties the pipeline
// and queue, sets the frame to its largest size and points at row 0,
// column 0. The line buffer needs no clearing pass.
`default_nettype none

module box_blur_3x3 #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 16
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // s_tdata: pixel_in[15:0]
    input  wire logic [bb3_pkg::S_TDATA_BITS-1:0]     s_tdata,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // m_tdata: out_row[9:0], out_col[19:10], pixel_out[35:20], zeros[39:36]
    output logic      [bb3_pkg::M_TDATA_BITS-1:0]     m_tdata,
    // m_tlast: run_last
    output logic                                      m_tlast,
    // m_tuser: frame_done
    output logic                                      m_tuser,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [bb3_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire logic [bb3_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    import bb3_pkg::*;

    localparam int CW        = $clog2(MAX_WIDTH);
    localparam int SUM_BITS  = PIXEL_BITS + 4;
    // floor(s / 9) = (s * DIV_MUL) >> DIV_SHIFT for every 9-pixel sum s.
    localparam int DIV_SHIFT = PIXEL_BITS + 8;
    localparam int MUL_BITS  = PIXEL_BITS + 5;
    localparam logic [MUL_BITS-1:0] DIV_MUL = MUL_BITS'(((2 ** DIV_SHIFT) + 8) / 9);
    localparam logic [CW-1:0] RST_WIDTH_LAST =
        CW'(((MAX_WIDTH < 1024) ? MAX_WIDTH : 1024) - 1);
    localparam int OCC_BITS  = RES_CNT_BITS + 1;

    // ---------------- configuration and position counters ----------------
    logic [CW-1:0]       width_last_reg, width_last_next;
    logic [ROW_BITS-1:0] height_last_reg, height_last_next;
    logic [CW-1:0]       col_reg, col_next;
    logic [ROW_BITS-1:0] row_reg, row_next;
    logic                cfg_write;
    logic                restart;
    logic                accept;
    logic                at_last_col;
    logic                at_last_row;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign accept    = s_tvalid && s_tready;
    assign at_last_col = (col_reg == width_last_reg);
    assign at_last_row = (row_reg == height_last_reg);

    always_comb begin
        width_last_next  = width_last_reg;
        height_last_next = height_last_reg;
        restart          = 1'b0;
        if (cfg_write) begin
            case (cfg_index)
                REG_FRAME_WIDTH: begin
                    restart = 1'b1;
                    if (cfg_data == '0) begin
                        width_last_next = '0;
                    end else if (32'(cfg_data) > 32'(MAX_WIDTH)) begin
                        width_last_next = CW'(MAX_WIDTH - 1);
                    end else begin
                        width_last_next = CW'(cfg_data - 11'd1);
                    end
                end
                REG_FRAME_HEIGHT: begin
                    restart = 1'b1;
                    if (cfg_data == '0) begin
                        height_last_next = '0;
                    end else if (32'(cfg_data) > 32'(MAX_ROWS)) begin
                        height_last_next = ROW_BITS'(MAX_ROWS - 1);
                    end else begin
                        height_last_next = ROW_BITS'(cfg_data - 11'd1);
                    end
                end
                default: begin
                    restart = 1'b0;
                end
            endcase
        end

        col_next = col_reg;
        row_next = row_reg;
        if (restart) begin
            col_next = '0;
            row_next = '0;
        end else if (accept) begin
            if (at_last_col) begin
                col_next = '0;
                row_next = at_last_row ? '0 : row_reg + 1'b1;
            end else begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_last_reg  <= RST_WIDTH_LAST;
            height_last_reg <= ROW_BITS'(MAX_ROWS - 1);
            col_reg         <= '0;
            row_reg         <= '0;
        end else begin
            width_last_reg  <= width_last_next;
            height_last_reg <= height_last_next;
            col_reg         <= col_next;
            row_reg         <= row_next;
        end
    end

    // ---------------- stage 1: line buffer read, window sum ----------------
    logic                  s1_valid_reg;
    logic [PIXEL_BITS-1:0] s1_pix_reg;
    logic [CW-1:0]         s1_col_reg;
    logic [ROW_BITS-1:0]   s1_row_reg;
    logic                  s1_emit_a_reg, s1_interior_reg, s1_emit_b_reg;
    logic                  s1_emit_c_reg, s1_done_reg;
    logic                  s1_byp_reg;
    logic [2*PIXEL_BITS-1:0] s1_byp_data_reg;

    logic [2*PIXEL_BITS-1:0] lb_rd_data;
    logic [2*PIXEL_BITS-1:0] lb_wr_data;
    logic [2*PIXEL_BITS-1:0] lb_pair;
    logic [PIXEL_BITS-1:0]   s1_top;
    logic [PIXEL_BITS-1:0]   s1_mid;
    logic [SUM_BITS-1:0]     s1_sum;
    logic [PIXEL_BITS-1:0]   win_reg [6];

    bb3_line_buf #(
        .DEPTH     (MAX_WIDTH),
        .DATA_BITS (2 * PIXEL_BITS)
    ) u_line_buf (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (lb_rd_data),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_col_reg),
        .wr_data (lb_wr_data)
    );

    // A one-pixel-wide frame reads the column that is being written in the
    // same cycle, so that pair is taken straight from stage 1.
    assign lb_pair    = s1_byp_reg ? s1_byp_data_reg : lb_rd_data;
    assign s1_top     = lb_pair[PIXEL_BITS-1:0];
    assign s1_mid     = lb_pair[2*PIXEL_BITS-1:PIXEL_BITS];
    assign lb_wr_data = {s1_pix_reg, s1_mid};

    always_comb begin
        s1_sum = SUM_BITS'(s1_top) + SUM_BITS'(s1_mid) + SUM_BITS'(s1_pix_reg);
        for (int k = 0; k < 6; k++) begin
            s1_sum = s1_sum + SUM_BITS'(win_reg[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_pix_reg      <= s_tdata[PIXEL_BITS-1:0];
            s1_col_reg      <= col_reg;
            s1_row_reg      <= row_reg;
            s1_emit_a_reg   <= (row_reg != '0) && (col_reg != '0);
            s1_interior_reg <= (row_reg >= ROW_BITS'(2)) && (col_reg >= CW'(2));
            s1_emit_b_reg   <= (row_reg != '0) && at_last_col;
            s1_emit_c_reg   <= at_last_row;
            s1_done_reg     <= at_last_row && at_last_col;
            s1_byp_reg      <= s1_valid_reg && (s1_col_reg == col_reg);
            s1_byp_data_reg <= lb_wr_data;
        end
        if (s1_valid_reg) begin
            win_reg[3] <= win_reg[0];
            win_reg[4] <= win_reg[1];
            win_reg[5] <= win_reg[2];
            win_reg[0] <= s1_top;
            win_reg[1] <= s1_mid;
            win_reg[2] <= s1_pix_reg;
        end
    end

    // ---------------- stage 2: divide by nine, build results ----------------
    logic                  s2_valid_reg;
    logic                  s2_emit_a_reg, s2_interior_reg, s2_emit_b_reg;
    logic                  s2_emit_c_reg, s2_done_reg;
    logic [ROW_BITS-1:0]   s2_row_reg;
    logic [CW-1:0]         s2_col_reg;
    logic [SUM_BITS-1:0]   s2_sum_reg;
    logic [PIXEL_BITS-1:0] s2_pass_reg;
    logic [PIXEL_BITS-1:0] s2_mid_reg;
    logic [PIXEL_BITS-1:0] s2_bot_reg;

    logic [SUM_BITS+MUL_BITS-1:0] s2_product;
    logic [PIXEL_BITS-1:0]        s2_mean;
    push_t                        push;
    result_t                      head;
    logic [RES_CNT_BITS-1:0]      fifo_count;
    logic [OCC_BITS-1:0]          occupancy;
    logic                         pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            s2_emit_a_reg   <= s1_emit_a_reg;
            s2_interior_reg <= s1_interior_reg;
            s2_emit_b_reg   <= s1_emit_b_reg;
            s2_emit_c_reg   <= s1_emit_c_reg;
            s2_done_reg     <= s1_done_reg;
            s2_row_reg      <= s1_row_reg;
            s2_col_reg      <= s1_col_reg;
            s2_sum_reg      <= s1_sum;
            s2_pass_reg     <= win_reg[1];
            s2_mid_reg      <= s1_mid;
            s2_bot_reg      <= s1_pix_reg;
        end
    end

    assign s2_product = SUM_BITS'(s2_sum_reg) * DIV_MUL;
    assign s2_mean    = s2_product[DIV_SHIFT +: PIXEL_BITS];

    // Results go out in this order: the pixel one up and one left of the
    // input, the last pixel of the row above at the end of a row, and the
    // input pixel itself on the bottom row.
    always_comb begin
        result_t    res_a;
        result_t    res_b;
        result_t    res_c;
        logic [1:0] idx;

        res_a.row        = s2_row_reg - 1'b1;
        res_a.col        = COL_BITS'(s2_col_reg - 1'b1);
        res_a.pixel      = PIX_OUT_BITS'(s2_interior_reg ? s2_mean : s2_pass_reg);
        res_a.run_last   = 1'b0;
        res_a.frame_done = s2_done_reg;

        res_b.row        = s2_row_reg - 1'b1;
        res_b.col        = COL_BITS'(s2_col_reg);
        res_b.pixel      = PIX_OUT_BITS'(s2_mid_reg);
        res_b.run_last   = 1'b0;
        res_b.frame_done = s2_done_reg;

        res_c.row        = s2_row_reg;
        res_c.col        = COL_BITS'(s2_col_reg);
        res_c.pixel      = PIX_OUT_BITS'(s2_bot_reg);
        res_c.run_last   = 1'b0;
        res_c.frame_done = s2_done_reg;

        push = '0;
        idx  = '0;
        if (s2_valid_reg) begin
            if (s2_emit_a_reg) begin
                push.item[idx] = res_a;
                idx = idx + 1'b1;
            end
            if (s2_emit_b_reg) begin
                push.item[idx] = res_b;
                idx = idx + 1'b1;
            end
            if (s2_emit_c_reg) begin
                push.item[idx] = res_c;
                idx = idx + 1'b1;
            end
            if (idx != '0) begin
                push.item[idx - 1'b1].run_last = 1'b1;
            end
        end
        push.count = idx;
    end

    bb3_res_fifo u_res_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (pop),
        .head    (head),
        .count   (fifo_count)
    );

    // Room is kept for the full run of every pixel in flight plus one more.
    assign occupancy = OCC_BITS'(fifo_count)
                     + (s1_valid_reg ? OCC_BITS'(RUN_MAX) : '0)
                     + (s2_valid_reg ? OCC_BITS'(RUN_MAX) : '0);
    assign s_tready  = (occupancy <= OCC_BITS'(RES_DEPTH - RUN_MAX));

    assign m_tvalid = (fifo_count != '0);
    assign pop      = m_tvalid && m_tready;
    assign m_tdata  = {(M_TDATA_BITS - ROW_BITS - COL_BITS - PIX_OUT_BITS)'(0),
                       head.pixel, head.col, head.row};
    assign m_tlast  = head.run_last;
    assign m_tuser  = head.frame_done;

endmodule

`default_nettype wire

FILE: rtl/core/bb3_checker.sv
// Port-level checks of the box blur, bound to every instance of the top level.
// Depends on bb3_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module bb3_checker (
    input wire logic                                 aclk,
    input wire logic                                 aresetn,
    input wire logic                                 s_tvalid,
    input wire logic                                 s_tready,
    input wire logic                                 m_tvalid,
    input wire logic                                 m_tready,
    input wire logic [bb3_pkg::M_TDATA_BITS-1:0]     m_tdata,
    input wire logic                                 m_tlast,
    input wire logic                                 m_tuser
);

    import bb3_pkg::*;

    // A result offered while the receiver stalls stays as it is.
    `BB3_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "result changed under stall")

    // All results of one pixel are queued together, so a run never breaks up.
    `BB3_ASSERT_NEXT(a_run_whole, m_tvalid && m_tready && !m_tlast, m_tvalid, "run of results broke up")

    // Every result of the frame's final pixel carries the frame mark.
    `BB3_ASSERT_NEXT(a_done_run, m_tvalid && m_tready && m_tuser && !m_tlast, m_tuser, "frame mark dropped inside a run")

    // An empty output only fills from an accepted pixel that went through both stages.
    `BB3_ASSERT_IMP(a_latency, $rose(m_tvalid), $past(s_tvalid && s_tready, 3), "result without a matching request")

endmodule

bind box_blur_3x3 bb3_checker u_bb3_checker (.*);

`default_nettype wire
